[hdl/pfvc_pkg.sv]
`default_nettype none

package pfvc_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PRESSURE_LIMIT    = 3'd0,
        CFG_TARGET_LOW        = 3'd1,
        CFG_TARGET_HIGH       = 3'd2,
        CFG_FILTER_WEIGHT     = 3'd3,
        CFG_DECISION_INTERVAL = 3'd4
    } cfg_index_t;

    // Configuration reset values.
    localparam logic [14:0] PRESSURE_LIMIT_RST = 15'd22000;
    localparam logic [14:0] TARGET_LOW_RST     = 15'd21000;
    localparam logic [14:0] TARGET_HIGH_RST    = 15'd16000;
    localparam logic [10:0] FILTER_WEIGHT_RST  = 11'd307;
    localparam logic [15:0] INTERVAL_RST       = 16'd1;

    // A filter weight of one whole, in units of 1/1024.
    localparam logic [10:0] WEIGHT_ONE = 11'd1024;

    // One sample set for one channel.
    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] pressure_sample;
        logic [9:0]         knob_sample;
        logic               button_level;
        logic [31:0]        now_ms;
    } sample_t;

    // One result for one channel.
    typedef struct packed {
        logic [1:0]         out_channel;
        logic               fill_valve;
        logic               vent_valve;
        logic signed [15:0] smoothed_pressure;
        logic [14:0]        target_pressure;
        logic               press_event;
        logic               rules_ran;
    } result_t;

    // Item handed to the valve decision stage.
    typedef struct packed {
        logic [1:0]         channel;
        logic               in_range;
        logic signed [15:0] pressure;
        logic [14:0]        target;
        logic               button_level;
        logic [31:0]        now_ms;
    } dec_item_t;

    // Per-channel state kept by the valve decision stage.
    typedef struct packed {
        logic        prev_button;
        logic        filling;
        logic        venting;
        logic        fill;
        logic        vent;
        logic [31:0] last_time;
    } dec_state_t;

endpackage

`default_nettype wire

[hdl/pneumatic_fill_vent_controller.sv]
// Pipeline: filter, knob product, quotient estimate, quotient correction and valve
// decision stages, then the output register. Throughput: one transaction per cycle
// unless result_ready stalls it, also on a single channel, set by the filter and
// valve-state memories' read-modify-write with registered read and neighbor forwarding.
// Reset: configuration returns to its defaults and all per-channel state reads
// as zero at once through per-entry valid bits; no clearing pass is needed.
`default_nettype none

module pneumatic_fill_vent_controller #(
    parameter int CHANNELS = 4
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_write_en,
    input  wire [pfvc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [pfvc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                 sample_valid,
    output logic                                sample_ready,
    input  pfvc_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  wire                                 result_ready,
    output pfvc_pkg::result_t                   result
);
    import pfvc_pkg::*;

    localparam int DEPTH = (CHANNELS < 4) ? CHANNELS : 4;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic signed [15:0] p;
        logic [9:0]         k;
    } filt_state_t;

    typedef struct packed {
        logic [1:0]         channel;
        logic               in_range;
        logic signed [15:0] p;
        logic               level;
        logic [31:0]        now_ms;
    } pass_t;

    // Configuration registers.
    logic [14:0] pressure_limit_reg;
    logic [14:0] target_low_reg;
    logic [14:0] target_high_reg;
    logic [10:0] filter_weight_reg;
    logic [15:0] interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_limit_reg <= PRESSURE_LIMIT_RST;
            target_low_reg     <= TARGET_LOW_RST;
            target_high_reg    <= TARGET_HIGH_RST;
            filter_weight_reg  <= FILTER_WEIGHT_RST;
            interval_reg       <= INTERVAL_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_PRESSURE_LIMIT:    pressure_limit_reg <= cfg_data[14:0];
                CFG_TARGET_LOW:        target_low_reg     <= cfg_data[14:0];
                CFG_TARGET_HIGH:       target_high_reg    <= cfg_data[14:0];
                CFG_FILTER_WEIGHT:     filter_weight_reg  <= cfg_data[10:0];
                CFG_DECISION_INTERVAL: interval_reg       <= cfg_data[15:0];
                default:               ;
            endcase
        end
    end

    // Pipeline occupancy and the ready chain from the output backward.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic result_valid_reg;
    logic free1, free2, free3, free4, free5, free_out;

    assign free_out     = !result_valid_reg || result_ready;
    assign free5        = !v5_reg || free_out;
    assign free4        = !v4_reg || free5;
    assign free3        = !v3_reg || free4;
    assign free2        = !v2_reg || free3;
    assign free1        = !v1_reg || free2;
    assign sample_ready = free1;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (free1)
                v1_reg <= sample_valid;
            if (free2)
                v2_reg <= v1_reg;
            if (free3)
                v3_reg <= v2_reg;
            if (free4)
                v4_reg <= v3_reg;
            if (free5)
                v5_reg <= v4_reg;
            if (free_out)
                result_valid_reg <= v5_reg;
        end
    end

    // Stage 1: filter memory read-modify-write.
    filt_state_t      fmem [DEPTH];
    logic [DEPTH-1:0] fvalid_reg;
    filt_state_t      fq_reg;
    logic             fq_valid_reg;
    logic             f_byp_reg;
    filt_state_t      f_byp_data_reg;
    sample_t          s1_reg;
    logic             s1_inr_reg;

    logic          accept;
    logic          f_write;
    logic          in_range;
    logic [AW-1:0] f_rd_addr;
    logic [AW-1:0] f_wr_addr;
    filt_state_t   f_old;
    filt_state_t   f_new;
    logic [10:0]   w_eff;
    logic signed [16:0] p_diff;
    logic signed [28:0] p_prod;
    logic signed [28:0] p_acc;
    logic signed [28:0] p_rnd;
    logic signed [10:0] k_diff;
    logic signed [22:0] k_prod;
    logic [22:0]        k_acc;

    assign accept    = sample_valid && free1;
    assign f_write   = v1_reg && free2 && s1_inr_reg;
    assign in_range  = {30'd0, sample.channel} < 32'(CHANNELS);
    assign f_rd_addr = sample.channel[AW-1:0];
    assign f_wr_addr = s1_reg.channel[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg         <= sample;
            s1_inr_reg     <= in_range;
            fq_reg         <= fmem[f_rd_addr];
            f_byp_data_reg <= f_new;
        end
        if (f_write)
        begin
            fmem[f_wr_addr] <= f_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvalid_reg   <= '0;
            fq_valid_reg <= 1'b0;
            f_byp_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fq_valid_reg <= fvalid_reg[f_rd_addr];
                f_byp_reg    <= f_write && (s1_reg.channel == sample.channel);
            end
            if (f_write)
            begin
                fvalid_reg[f_wr_addr] <= 1'b1;
            end
        end
    end

    // Old filter values, forwarded when the previous transaction wrote the same entry.
    always_comb
    begin
        if (f_byp_reg)
            f_old = f_byp_data_reg;
        else if (fq_valid_reg)
            f_old = fq_reg;
        else
            f_old = '0;
    end

    // Weighted average written as old + w * (new - old), divided by 1024 toward zero.
    assign w_eff  = (filter_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : filter_weight_reg;
    assign p_diff = {s1_reg.pressure_sample[15], s1_reg.pressure_sample}
                    - {f_old.p[15], f_old.p};
    assign p_prod = $signed({1'b0, w_eff}) * p_diff;
    assign p_acc  = p_prod + $signed({{3{f_old.p[15]}}, f_old.p, 10'd0});
    assign p_rnd  = p_acc + (p_acc[28] ? 29'sd1023 : 29'sd0);
    assign k_diff = $signed({1'b0, s1_reg.knob_sample}) - $signed({1'b0, f_old.k});
    assign k_prod = $signed({1'b0, w_eff}) * k_diff;
    assign k_acc  = 23'(k_prod) + {3'd0, f_old.k, 10'd0};

    always_comb
    begin
        f_new.p = p_rnd[25:10];
        f_new.k = k_acc[19:10];
    end

    // Stage 2: knob-to-target product.
    pass_t              s2_reg;
    logic [9:0]         k2_reg;
    logic signed [15:0] t_diff;
    logic signed [26:0] t_prod;

    always_ff @(posedge clk)
    begin
        if (free2)
        begin
            s2_reg.channel  <= s1_reg.channel;
            s2_reg.in_range <= s1_inr_reg;
            s2_reg.p        <= f_new.p;
            s2_reg.level    <= s1_reg.button_level;
            s2_reg.now_ms   <= s1_reg.now_ms;
            k2_reg          <= f_new.k;
        end
    end

    assign t_diff = $signed({1'b0, target_high_reg}) - $signed({1'b0, target_low_reg});
    assign t_prod = $signed({1'b0, k2_reg}) * t_diff;

    // Stage 3: magnitude and quotient estimate for the division by 1023.
    pass_t              s3_reg;
    logic signed [26:0] t_prod3_reg;
    logic               neg3;
    logic [24:0]        mag3;
    logic [25:0]        est_sum;

    always_ff @(posedge clk)
    begin
        if (free3)
        begin
            s3_reg      <= s2_reg;
            t_prod3_reg <= t_prod;
        end
    end

    assign neg3    = t_prod3_reg[26];
    assign mag3    = neg3 ? 25'(-t_prod3_reg) : 25'(t_prod3_reg);
    assign est_sum = 26'(mag3) + 26'(mag3 >> 10) + 26'(mag3 >> 20);

    // Stage 4: one-step quotient correction and the target pressure.
    pass_t              s4_reg;
    logic               neg4_reg;
    logic [24:0]        mag4_reg;
    logic [14:0]        q0_reg;
    logic [25:0]        rem;
    logic [14:0]        quot;
    logic signed [16:0] tgt_full;
    dec_item_t          dec_item;

    always_ff @(posedge clk)
    begin
        if (free4)
        begin
            s4_reg   <= s3_reg;
            neg4_reg <= neg3;
            mag4_reg <= mag3;
            q0_reg   <= est_sum[24:10];
        end
    end

    assign rem      = 26'(mag4_reg) - 26'({q0_reg, 10'd0}) + 26'(q0_reg);
    assign quot     = q0_reg + 15'(rem >= 26'd1023);
    assign tgt_full = $signed({2'b0, target_low_reg})
                      + (neg4_reg ? -$signed({2'b0, quot}) : $signed({2'b0, quot}));

    always_comb
    begin
        dec_item.channel      = s4_reg.channel;
        dec_item.in_range     = s4_reg.in_range;
        dec_item.pressure     = s4_reg.p;
        dec_item.target       = tgt_full[14:0];
        dec_item.button_level = s4_reg.level;
        dec_item.now_ms       = s4_reg.now_ms;
    end

    // Stage 5: valve decision with its own state memory.
    result_t dec_result;

    pfvc_valve_ctl #(
        .DEPTH (DEPTH)
    ) u_valve_ctl (
        .clk            (clk),
        .rst_n          (rst_n),
        .enter          (v4_reg && free5),
        .leave          (v5_reg && free_out),
        .item           (dec_item),
        .pressure_limit (pressure_limit_reg),
        .interval_ms    (interval_reg),
        .result         (dec_result)
    );

    // Output register.
    always_ff @(posedge clk)
    begin
        if (free_out)
        begin
            result <= dec_result;
        end
    end

    // An accepted transaction always occupies the first stage next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> v1_reg)
        else $error("accepted transaction missing from first stage");

    // Filter forwarding only ever serves an in-range item in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && f_byp_reg |-> s1_inr_reg)
        else $error("filter forwarding armed without a matching item");

    // A new result only appears when the decision stage held an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(v5_reg))
        else $error("result appeared without a decision-stage item");

endmodule

`default_nettype wire

[hdl/pfvc_valve_ctl.sv]
`default_nettype none

module pfvc_valve_ctl #(
    parameter int DEPTH = 4
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    enter,
    input  wire                    leave,
    input  pfvc_pkg::dec_item_t    item,
    input  wire [14:0]             pressure_limit,
    input  wire [15:0]             interval_ms,
    output pfvc_pkg::result_t      result
);
    import pfvc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Per-channel decision state; entries without a valid bit read as zero.
    dec_state_t       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    dec_item_t  item_reg;
    dec_state_t rd_reg;
    logic       rd_valid_reg;
    logic       byp_reg;
    dec_state_t byp_data_reg;

    dec_state_t cur;
    dec_state_t nxt;
    logic       pressed;
    logic       ran;
    logic       write_en;
    logic [31:0] elapsed;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign rd_addr  = item.channel[AW-1:0];
    assign wr_addr  = item_reg.channel[AW-1:0];
    assign write_en = leave && item_reg.in_range;

    // Capture the entering transaction and read its channel's state.
    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            item_reg     <= item;
            rd_reg       <= mem[rd_addr];
            byp_data_reg <= nxt;
        end
        if (write_en)
        begin
            mem[wr_addr] <= nxt;
        end
    end

    // Valid bits and forwarding control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (enter)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                byp_reg      <= write_en && (item_reg.channel == item.channel);
            end
            if (write_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Current state: forwarded from the previous transaction when it wrote the same entry.
    always_comb
    begin
        if (byp_reg)
        begin
            cur = byp_data_reg;
        end
        else if (rd_valid_reg)
        begin
            cur = rd_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    assign elapsed = item_reg.now_ms - cur.last_time;

    // Safety close, press detection and the fill/hold/vent rules.
    always_comb
    begin
        nxt     = cur;
        pressed = !item_reg.button_level && cur.prev_button;
        ran     = elapsed > {16'd0, interval_ms};
        nxt.prev_button = item_reg.button_level;
        if (item_reg.pressure >= $signed({1'b0, pressure_limit}))
        begin
            nxt.fill = 1'b0;
        end
        if (ran)
        begin
            nxt.last_time = item_reg.now_ms;
            if ((item_reg.pressure < $signed({1'b0, item_reg.target})) && pressed)
            begin
                nxt.fill    = 1'b1;
                nxt.vent    = 1'b0;
                nxt.filling = 1'b1;
            end
            else if ((item_reg.pressure > $signed({1'b0, item_reg.target})) && cur.filling)
            begin
                nxt.fill    = 1'b0;
                nxt.vent    = 1'b0;
                nxt.filling = 1'b0;
            end
            else if ((item_reg.pressure > $signed({1'b0, item_reg.target})) && pressed)
            begin
                nxt.fill    = 1'b0;
                nxt.vent    = 1'b1;
                nxt.venting = 1'b1;
            end
            else if ((item_reg.pressure < $signed({1'b0, item_reg.target})) && cur.venting)
            begin
                nxt.fill    = 1'b0;
                nxt.vent    = 1'b0;
                nxt.venting = 1'b0;
            end
        end
    end

    // Result fields; a channel beyond the configured count reports zeros in all but its channel.
    always_comb
    begin
        result             = '0;
        result.out_channel = item_reg.channel;
        if (item_reg.in_range)
        begin
            result.fill_valve        = nxt.fill;
            result.vent_valve        = nxt.vent;
            result.smoothed_pressure = item_reg.pressure;
            result.target_pressure   = item_reg.target;
            result.press_event       = pressed;
            result.rules_ran         = ran;
        end
    end

endmodule

`default_nettype wire
